// ===== rtl/core/pqz_pkg.sv =====
// ----------------------------------------------------------------------------
// pqz_pkg
// Shared widths, register codes, pitch grid and helpers for the dual-scale
// pitch quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pqz_pkg;

  localparam int CH_W         = 4;
  localparam int PITCH_W      = 18;
  localparam int RND_W        = 48;
  localparam int LEVEL_W      = 5;
  localparam int FACTOR_W     = 5;
  localparam int CLASSES      = 12;
  localparam int LEVELS_W     = LEVEL_W * CLASSES;
  localparam int NIBBLE_W     = 4;
  localparam int CLASS_W      = 4;
  localparam int FRAC_W       = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = LEVELS_W;
  localparam int CHANNELS_DEF = 16;

  // pitch units per volt, and the offset that makes any 18-bit pitch positive
  localparam int STEPS        = 10000;
  localparam int PITCH_OFFSET = 14 * STEPS;
  localparam int U_W          = 19;
  localparam int Q_W          = 5;
  localparam int SUM_W        = 20;
  // floor(u / STEPS) == (u * RECIP) >> RECIP_SHIFT, exact for u < 2^19
  localparam int RECIP        = 429497;
  localparam int RECIP_SHIFT  = 32;
  localparam int PROD_W       = 2 * U_W;

  localparam int PITCH_MAX    = 131071;
  localparam int PITCH_MIN    = -131072;
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_ONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_TWO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIQUE_ONE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNIQUE_TWO = 3'd3;

  typedef struct packed {
    logic               found;
    logic [CLASS_W-1:0] idx;
  } pqz_pick_t;

  function automatic logic [LEVEL_W-1:0] sat16(input logic [LEVEL_W-1:0] v);
    return (v > LEVEL_FULL) ? LEVEL_FULL : v;
  endfunction

  function automatic logic [FRAC_W-1:0] grid_at(input logic [CLASS_W-1:0] j);
    logic [FRAC_W-1:0] g;
    unique case (j)
      4'd0:    g = 14'd0;
      4'd1:    g = 14'd833;
      4'd2:    g = 14'd1666;
      4'd3:    g = 14'd2500;
      4'd4:    g = 14'd3333;
      4'd5:    g = 14'd4166;
      4'd6:    g = 14'd5000;
      4'd7:    g = 14'd5833;
      4'd8:    g = 14'd6666;
      4'd9:    g = 14'd7500;
      4'd10:   g = 14'd8333;
      4'd11:   g = 14'd9166;
      default: g = 14'd0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pqz_nearest.sv =====
// ----------------------------------------------------------------------------
// pqz_nearest
// Picks the eligible pitch class nearest to the position within the volt;
// the lower class wins a tie.
// ----------------------------------------------------------------------------
`default_nettype none

module pqz_nearest (
  input  wire logic [pqz_pkg::FRAC_W-1:0]  frac,
  input  wire logic [pqz_pkg::CLASSES-1:0] elig,
  output pqz_pkg::pqz_pick_t               pick
);
  import pqz_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [CLASS_W-1:0] idx;
    logic [FRAC_W-1:0]  gap;
  } cand_t;

  // a always carries the lower class indexes
  function automatic cand_t merge(input cand_t a, input cand_t b);
    return (a.ok && (!b.ok || a.gap <= b.gap)) ? a : b;
  endfunction

  cand_t leaf [CLASSES];
  cand_t lvl1 [6];
  cand_t lvl2 [3];
  cand_t lvl3;
  cand_t best;

  genvar j;
  for (j = 0; j < CLASSES; j++) begin : g_leaf
    logic [FRAC_W-1:0] g;
    assign g = grid_at(CLASS_W'(j));
    assign leaf[j].ok  = elig[j];
    assign leaf[j].idx = CLASS_W'(j);
    assign leaf[j].gap = (frac >= g) ? (frac - g) : (g - frac);
  end

  for (j = 0; j < 6; j++) begin : g_lvl1
    assign lvl1[j] = merge(leaf[2*j], leaf[2*j+1]);
  end

  for (j = 0; j < 3; j++) begin : g_lvl2
    assign lvl2[j] = merge(lvl1[2*j], lvl1[2*j+1]);
  end

  assign lvl3 = merge(lvl2[0], lvl2[1]);
  assign best = merge(lvl3, lvl2[2]);

  assign pick.found = best.ok;
  assign pick.idx   = best.idx;

endmodule

`default_nettype wire

// ===== rtl/core/probabilistic_dual_scale_quantizer_core.sv =====
// ----------------------------------------------------------------------------
// probabilistic_dual_scale_quantizer_core
// Per-channel pitch quantizer over two weighted scales with random selection.
//
// Input channel (in_valid/in_stall) carries one sample of a multiplexed
// channel; output channel (out_valid/out_stall) returns one result per
// transfer, in order. A rising trigger on a channel quantizes its pitch to
// the nearest eligible pitch class; otherwise the channel's held pitch repeats.
// Results leave through the output register; one item per cycle is
// taken while the output is not stalled. The four-stage pipeline (input,
// divide by 10000 and eligibility, fraction, nearest-class pick and channel
// state) advances as a whole, so out_stall with a full output register
// freezes every stage and raises in_stall the same cycle.
// Config writes (cfg_we) are taken at any time, meant only while idle.
// Reset empties the pipeline, restores register defaults, marks every trigger
// high (no edge at start) and clears the held pitches; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module probabilistic_dual_scale_quantizer_core #(
  parameter int CHANNELS = pqz_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pqz_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pqz_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pqz_pkg::CH_W-1:0]          channel,
  input  wire logic                              trigger_high,
  input  wire logic signed [pqz_pkg::PITCH_W-1:0] pitch_volts,
  input  wire logic [pqz_pkg::RND_W-1:0]         random_bits,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [pqz_pkg::CH_W-1:0]               out_channel,
  output logic signed [pqz_pkg::PITCH_W-1:0]     pitch_out,
  output logic                                   fresh,
  output logic                                   none_eligible
);
  import pqz_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [LEVELS_W-1:0] scale_one;
  logic [LEVELS_W-1:0] scale_two;
  logic [FACTOR_W-1:0] factor_one;
  logic [FACTOR_W-1:0] factor_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_one  <= {CLASSES{LEVEL_FULL}};
      scale_two  <= {CLASSES{LEVEL_FULL}};
      factor_one <= LEVEL_FULL;
      factor_two <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_ONE:  scale_one  <= cfg_data;
        REG_SCALE_TWO:  scale_two  <= cfg_data;
        REG_UNIQUE_ONE: factor_one <= cfg_data[FACTOR_W-1:0];
        REG_UNIQUE_TWO: factor_two <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: input register
  logic                      s1_valid;
  logic [CH_W-1:0]           s1_channel;
  logic                      s1_trig;
  logic signed [PITCH_W-1:0] s1_pitch;
  logic [RND_W-1:0]          s1_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_channel <= channel;
      s1_trig    <= trigger_high;
      s1_pitch   <= pitch_volts;
      s1_rnd     <= random_bits;
    end
  end

  // stage 2: volt number by reciprocal multiply, class eligibility
  logic [SUM_W-1:0]   u_sum;
  logic [U_W-1:0]     u_next;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     q_next;
  logic [FACTOR_W-1:0] f1;
  logic [FACTOR_W-1:0] f2;
  logic [CLASSES-1:0] elig_next;

  assign u_sum  = SUM_W'(s1_pitch) + SUM_W'(PITCH_OFFSET);
  assign u_next = u_sum[U_W-1:0];
  assign prod   = PROD_W'(u_next) * PROD_W'(RECIP);
  assign q_next = prod[RECIP_SHIFT +: Q_W];
  assign f1     = sat16(factor_one);
  assign f2     = sat16(factor_two);

  genvar j;
  for (j = 0; j < CLASSES; j++) begin : g_cls
    logic [LEVEL_W-1:0]   p1r, p2r, p1, p2, pm;
    logic [2*LEVEL_W-1:0] m1, m2;
    assign p1r = sat16(scale_one[LEVEL_W*j +: LEVEL_W]);
    assign p2r = sat16(scale_two[LEVEL_W*j +: LEVEL_W]);
    assign m1  = (2*LEVEL_W)'(p1r) * (2*LEVEL_W)'(f1);
    assign m2  = (2*LEVEL_W)'(p2r) * (2*LEVEL_W)'(f2);
    // a class present in one scale only is weighted by that scale's factor
    assign p1  = (p1r != '0 && p2r == '0) ? m1[4 +: LEVEL_W] : p1r;
    assign p2  = (p2r != '0 && p1r == '0) ? m2[4 +: LEVEL_W] : p2r;
    assign pm  = (p1 > p2) ? p1 : p2;
    assign elig_next[j] = LEVEL_W'(s1_rnd[NIBBLE_W*j +: NIBBLE_W]) < pm;
  end

  logic               s2_valid;
  logic [CH_W-1:0]    s2_channel;
  logic               s2_trig;
  logic [U_W-1:0]     s2_u;
  logic [Q_W-1:0]     s2_q;
  logic [CLASSES-1:0] s2_elig;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_channel <= s1_channel;
      s2_trig    <= s1_trig;
      s2_u       <= u_next;
      s2_q       <= q_next;
      s2_elig    <= elig_next;
    end
  end

  // stage 3: position within the volt and the volt's base pitch
  logic [U_W-1:0]          qs;
  logic [U_W-1:0]          frac_full;
  logic [FRAC_W-1:0]       frac_next;
  logic signed [SUM_W-1:0] base_next;

  assign qs        = U_W'(s2_q) * U_W'(STEPS);
  assign frac_full = s2_u - qs;
  assign frac_next = frac_full[FRAC_W-1:0];
  assign base_next = SUM_W'(qs) - SUM_W'(PITCH_OFFSET);

  logic                    s3_valid;
  logic [CH_W-1:0]         s3_channel;
  logic                    s3_trig;
  logic [FRAC_W-1:0]       s3_frac;
  logic signed [SUM_W-1:0] s3_base;
  logic [CLASSES-1:0]      s3_elig;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_channel <= s2_channel;
      s3_trig    <= s2_trig;
      s3_frac    <= frac_next;
      s3_base    <= base_next;
      s3_elig    <= s2_elig;
    end
  end

  // stage 4: nearest class, channel state, result register
  pqz_pick_t pick;

  pqz_nearest u_nearest (
    .frac (s3_frac),
    .elig (s3_elig),
    .pick (pick)
  );

  logic [CHANNELS-1:0]       last_trig;
  logic signed [PITCH_W-1:0] held [CHANNELS];

  logic                      chan_ok;
  logic [IDX_W-1:0]          sidx;
  logic                      trig_edge;
  logic signed [SUM_W-1:0]   sum;
  logic signed [PITCH_W-1:0] sum_sat;
  logic signed [PITCH_W-1:0] q_res;
  logic signed [PITCH_W-1:0] pitch_next;

  assign chan_ok   = {1'b0, s3_channel} < (CH_W+1)'(CHANNELS);
  assign sidx      = IDX_W'(s3_channel);
  assign trig_edge = chan_ok && s3_trig && !last_trig[sidx];
  assign sum       = s3_base + SUM_W'(grid_at(pick.idx));

  always_comb begin
    priority if (sum > SUM_W'(PITCH_MAX)) begin
      sum_sat = PITCH_W'(PITCH_MAX);
    end else if (sum < SUM_W'(PITCH_MIN)) begin
      sum_sat = PITCH_W'(PITCH_MIN);
    end else begin
      sum_sat = sum[PITCH_W-1:0];
    end
  end

  assign q_res = pick.found ? sum_sat : '0;

  always_comb begin
    priority if (!chan_ok) begin
      pitch_next = '0;
    end else if (trig_edge) begin
      pitch_next = q_res;
    end else begin
      pitch_next = held[sidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_trig <= '1;
      for (int c = 0; c < CHANNELS; c++) begin
        held[c] <= '0;
      end
    end else if (adv && s3_valid && chan_ok) begin
      last_trig[sidx] <= s3_trig;
      if (trig_edge) begin
        held[sidx] <= q_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_channel   <= s3_channel;
      pitch_out     <= pitch_next;
      fresh         <= trig_edge;
      none_eligible <= trig_edge && !pick.found;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pqz_checker.sv =====
// ----------------------------------------------------------------------------
// pqz_checker
// Port-level checks for the dual-scale pitch quantizer, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module pqz_checker #(
  parameter int CHANNELS = pqz_pkg::CHANNELS_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [pqz_pkg::CH_W-1:0]           out_channel,
  input wire logic signed [pqz_pkg::PITCH_W-1:0] pitch_out,
  input wire logic                               fresh,
  input wire logic                               none_eligible
);
  import pqz_pkg::*;

  // a held result keeps its transfer intact
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pitch_out) &&
      $stable(out_channel) && $stable(fresh) && $stable(none_eligible))
    else $error("output changed while stalled");

  // input backs up only behind a stalled, full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && none_eligible |-> fresh && pitch_out == '0)
    else $error("no-eligible result not a fresh zero");

  a_fresh_chan: assert property (@(posedge clk) disable iff (rst)
    out_valid && fresh |-> {1'b0, out_channel} < (CH_W+1)'(CHANNELS))
    else $error("fresh result on an unsupported channel");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind probabilistic_dual_scale_quantizer_core pqz_checker #(
  .CHANNELS (CHANNELS)
) u_pqz_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_channel   (out_channel),
  .pitch_out     (pitch_out),
  .fresh         (fresh),
  .none_eligible (none_eligible)
);

`default_nettype wire
